// ===== hw/rtl/owdm_pkg.sv =====
// ----------------------------------------------------------------------------
// owdm_pkg
// Shared types and constants of the omnidirectional wheel drive mixer.
// ----------------------------------------------------------------------------
package owdm_pkg;

  localparam int WHEEL_COUNT   = 4;
  localparam int FRACTION_BITS = 14;
  localparam int ONE           = 1 << FRACTION_BITS;
  localparam int NEGLIGIBLE    = ONE / 1000;
  localparam int LANE_W        = 16;
  localparam int LEVEL_W       = 15;
  localparam int DVD_W         = 48;
  localparam int DVS_W         = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COSINES   = 4'd0,
    CFG_SINES     = 4'd1,
    CFG_ROT_GAINS = 4'd2,
    CFG_OUT_GAINS = 4'd3,
    CFG_FLAGS     = 4'd4,
    CFG_MAXIMUM   = 4'd5,
    CFG_MINIMUM   = 4'd6,
    CFG_NORMALIZE = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [LANE_W-1:0] translation_x;
    logic signed [LANE_W-1:0] translation_y;
    logic signed [LANE_W-1:0] rotation;
  } cmd_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] wheel_zero;
    logic signed [LANE_W-1:0] wheel_one;
    logic signed [LANE_W-1:0] wheel_two;
    logic signed [LANE_W-1:0] wheel_three;
  } res_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] direction_cosines;
    logic [CFG_DATA_W-1:0] direction_sines;
    logic [CFG_DATA_W-1:0] rotation_gains;
    logic [CFG_DATA_W-1:0] output_gains;
    logic [7:0]            wheel_flags;
    logic [LEVEL_W-1:0]    maximum_output;
    logic [LEVEL_W-1:0]    minimum_output;
    logic                  normalize_translation;
  } cfg_t;

  typedef struct packed {
    cmd_t cmd;
    logic normalize;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_MCHK, S_NC, S_NS, S_NCHK,
    S_NXM, S_NXW, S_NYM, S_NYW, S_PX, S_PY, S_PR, S_LCHK,
    S_SCL, S_SCLW, S_OG, S_OL, S_RM, S_RMW, S_EMIT
  } back_state_e;

endpackage

// ===== hw/rtl/omni_wheel_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer
// Four-wheel omnidirectional drive mixer: drive command in, wheel values out.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and raise start; the word is taken at a
//   clock edge where start is high and busy is low. busy rises only while
//   the four-entry command queue is full. The idle sequencer pulls a word
//   out in the cycle after it lands, so from idle up to five commands can
//   be handed over back to back, four waiting while the first is mixed.
//   Result channel: done_o is high for exactly one cycle with the four
//   wheel values on result_o. The receiver cannot stall; results come out
//   in command order.
//   Configuration channel: cfg_valid_i with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high. Write only while no command is in flight.
//   Indexes beyond the register list are dropped.
//   Sequencing: the back end mixes one command at a time with one shared
//   multiplier and a shared 48-step divider. Normalization, saturation
//   scaling and startup remap each add divisions; the next command can
//   start in the cycle of the result strobe.
//   Reset: the queue empties, the sequencer idles and the registers take
//   their defaults (unit gains, all wheels enabled, full power ceiling).
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer import owdm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd_i,
  output logic                  done_o,
  output res_t                  result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t   cfg_q, cfg_d;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  // decode a register write, mask each to its width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_COSINES:   cfg_d.direction_cosines     = cfg_data_i;
        CFG_SINES:     cfg_d.direction_sines       = cfg_data_i;
        CFG_ROT_GAINS: cfg_d.rotation_gains        = cfg_data_i;
        CFG_OUT_GAINS: cfg_d.output_gains          = cfg_data_i;
        CFG_FLAGS:     cfg_d.wheel_flags           = cfg_data_i[7:0];
        CFG_MAXIMUM:   cfg_d.maximum_output        = cfg_data_i[LEVEL_W-1:0];
        CFG_MINIMUM:   cfg_d.minimum_output        = cfg_data_i[LEVEL_W-1:0];
        CFG_NORMALIZE: cfg_d.normalize_translation = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction_cosines     <= '0;
      cfg_q.direction_sines       <= '0;
      cfg_q.rotation_gains        <= 64'h4000_4000_4000_4000;
      cfg_q.output_gains          <= 64'h4000_4000_4000_4000;
      cfg_q.wheel_flags           <= 8'h0f;
      cfg_q.maximum_output        <= LEVEL_W'(ONE);
      cfg_q.minimum_output        <= '0;
      cfg_q.normalize_translation <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // intake and queue
  owdm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .normalize_i (cfg_q.normalize_translation),
    .pop_i       (q_pop),
    .busy        (busy),
    .valid_o     (q_valid),
    .entry_o     (q_entry)
  );

  // mixing sequencer
  owdm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (q_valid),
    .entry_i  (q_entry),
    .pop_o    (q_pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== hw/rtl/owdm_div.sv =====
// ----------------------------------------------------------------------------
// owdm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module owdm_div import owdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/owdm_front.sv =====
// ----------------------------------------------------------------------------
// owdm_front
// Command intake: tag each command with its path and hold it in a short queue.
// ----------------------------------------------------------------------------
module owdm_front import owdm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  input  cmd_t   cmd_i,
  input  logic   normalize_i,
  input  logic   pop_i,
  output logic   busy,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign busy    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign push    = start && !busy;
  assign pop     = pop_i && valid_o;
  assign entry_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // tag the word with the path it takes through the back end
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= '{cmd: cmd_i, normalize: normalize_i};
    end
  end

endmodule

// ===== hw/rtl/owdm_back.sv =====
// ----------------------------------------------------------------------------
// owdm_back
// Sequencer with one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
module owdm_back import owdm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  input  entry_t entry_i,
  output logic   pop_o,
  output logic   done_o,
  output res_t   result_o
);

  localparam int XW = 28;
  localparam int VW = 30;
  localparam int PW = 45;
  localparam int AW = 46;

  localparam logic [1:0] LAST_WHEEL = 2'(WHEEL_COUNT - 1);

  back_state_e               st_q, st_d;
  logic [1:0]                k_q, k_d;
  logic signed [XW-1:0]      x_q, x_d, y_q, y_d;
  logic signed [LANE_W-1:0]  r_q, r_d;
  logic signed [AW-1:0]      acc_q, acc_d;
  logic [31:0]               rad_q, rad_d, root_q, root_d;
  logic [3:0]                iter_q, iter_d;
  logic [31:0]               p_q, p_d;
  logic signed [VW-1:0]      v_q [WHEEL_COUNT];
  logic signed [VW-1:0]      v_d [WHEEL_COUNT];
  logic [VW-1:0]             largest_q, largest_d;
  logic signed [17:0]        t_q, t_d;
  logic                      neg_q, neg_d;
  logic [LEVEL_W-1:0]        mag_q, mag_d;
  logic signed [LANE_W-1:0]  out_q [WHEEL_COUNT];
  logic signed [LANE_W-1:0]  out_d [WHEEL_COUNT];
  logic                      done_q, done_d;

  logic signed [XW-1:0]      mul_a;
  logic signed [16:0]        mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [AW-1:0]      prod_x, sum, sum_mag, trunc_p, trunc_s;
  logic signed [LANE_W-1:0]  cos_k, sin_k, rgain_k, ogain_k;
  logic [LEVEL_W-1:0]        lim, e_min;
  logic [31:0]               bit_w;
  logic [32:0]               trial;
  logic [VW-1:0]             v_mag;
  logic signed [17:0]        q_w;
  logic [17:0]               q_mag;
  logic [15:0]               rem_w;
  logic                      div_start;
  logic [DVD_W-1:0]          div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_done;
  logic [DVD_W-1:0]          div_quo;

  function automatic logic signed [AW-1:0] tdiv_one(input logic signed [AW-1:0] val);
    logic [AW-1:0] m;
    m = val[AW-1] ? AW'(-val) : AW'(val);
    m = m >> FRACTION_BITS;
    if (val[AW-1]) begin
      m = -m;
    end
    return m;
  endfunction

  assign cos_k   = cfg_i.direction_cosines[LANE_W*k_q +: LANE_W];
  assign sin_k   = cfg_i.direction_sines[LANE_W*k_q +: LANE_W];
  assign rgain_k = cfg_i.rotation_gains[LANE_W*k_q +: LANE_W];
  assign ogain_k = cfg_i.output_gains[LANE_W*k_q +: LANE_W];
  assign lim     = (cfg_i.maximum_output > LEVEL_W'(ONE)) ? LEVEL_W'(ONE)
                                                          : cfg_i.maximum_output;
  assign e_min   = (cfg_i.minimum_output < lim) ? cfg_i.minimum_output : lim;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_SQX:        begin mul_a = x_q; mul_b = x_q[16:0]; end
      S_SQY:        begin mul_a = y_q; mul_b = y_q[16:0]; end
      S_NC, S_PX:   begin mul_a = x_q; mul_b = 17'(cos_k); end
      S_NS, S_PY:   begin mul_a = y_q; mul_b = 17'(sin_k); end
      S_NXM:        begin mul_a = x_q; mul_b = {1'b0, root_q[15:0]}; end
      S_NYM:        begin mul_a = y_q; mul_b = {1'b0, root_q[15:0]}; end
      S_PR:         begin mul_a = XW'(r_q); mul_b = 17'(rgain_k); end
      S_OG:         begin mul_a = v_q[k_q][XW-1:0]; mul_b = 17'(ogain_k); end
      S_OL:         begin mul_a = XW'(t_q); mul_b = {2'b00, lim}; end
      S_RM:         begin
        mul_a = XW'({1'b0, lim - e_min});
        mul_b = {2'b00, mag_q};
      end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_x  = AW'(prod);
  assign sum     = acc_q + prod_x;
  assign sum_mag = sum[AW-1] ? -sum : sum;
  assign trunc_p = tdiv_one(prod_x);
  assign trunc_s = tdiv_one(sum);
  assign bit_w   = 32'(1) << (5'd30 - {iter_q, 1'b0});
  assign trial   = {1'b0, root_q} + {1'b0, bit_w};
  assign v_mag   = v_q[k_q][VW-1] ? VW'(-v_q[k_q]) : VW'(v_q[k_q]);

  always_comb begin
    st_d      = st_q;
    k_d       = k_q;
    x_d       = x_q;
    y_d       = y_q;
    r_d       = r_q;
    acc_d     = acc_q;
    rad_d     = rad_q;
    root_d    = root_q;
    iter_d    = iter_q;
    p_d       = p_q;
    v_d       = v_q;
    largest_d = largest_q;
    t_d       = t_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    out_d     = out_q;
    done_d    = 1'b0;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    q_w       = '0;
    q_mag     = '0;
    rem_w     = '0;
    unique case (st_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o     = 1'b1;
          x_d       = XW'(entry_i.cmd.translation_x);
          y_d       = XW'(entry_i.cmd.translation_y);
          r_d       = entry_i.cmd.rotation;
          largest_d = '0;
          k_d       = '0;
          st_d      = entry_i.normalize ? S_SQX : S_PX;
        end
      end
      S_SQX: begin
        acc_d = prod_x;
        st_d  = S_SQY;
      end
      S_SQY: begin
        rad_d  = sum[31:0];
        root_d = '0;
        iter_d = '0;
        st_d   = S_ROOT;
      end
      S_ROOT: begin
        // one digit of the integer square root
        if ({1'b0, rad_q} >= trial) begin
          rad_d  = rad_q - trial[31:0];
          root_d = (root_q >> 1) + bit_w;
        end else begin
          root_d = root_q >> 1;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == 4'hf) begin
          st_d = S_MCHK;
        end
      end
      S_MCHK: begin
        k_d = '0;
        p_d = '0;
        st_d = (root_q < 32'(NEGLIGIBLE)) ? S_PX : S_NC;
      end
      S_NC: begin
        acc_d = prod_x;
        st_d  = S_NS;
      end
      S_NS: begin
        if (sum_mag[31:0] > p_q) begin
          p_d = sum_mag[31:0];
        end
        k_d  = k_q + 1'b1;
        st_d = (k_q == LAST_WHEEL) ? S_NCHK : S_NC;
      end
      S_NCHK: begin
        k_d  = '0;
        st_d = (36'(p_q) >= 36'(root_q[15:0]) * 36'(NEGLIGIBLE)) ? S_NXM : S_PX;
      end
      S_NXM, S_NYM: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_x[AW-1] ? -prod_x : prod_x) << FRACTION_BITS;
        div_dvs   = p_q;
        neg_d     = prod_x[AW-1];
        st_d      = (st_q == S_NXM) ? S_NXW : S_NYW;
      end
      S_NXW: begin
        if (div_done) begin
          x_d  = neg_q ? -XW'(div_quo) : XW'(div_quo);
          st_d = S_NYM;
        end
      end
      S_NYW: begin
        if (div_done) begin
          y_d  = neg_q ? -XW'(div_quo) : XW'(div_quo);
          st_d = S_PX;
        end
      end
      S_PX: begin
        acc_d = prod_x;
        st_d  = S_PY;
      end
      S_PY: begin
        acc_d = sum;
        st_d  = S_PR;
      end
      S_PR: begin
        v_d[k_q] = VW'(trunc_s);
        if ((trunc_s[AW-1] ? VW'(-trunc_s) : VW'(trunc_s)) > largest_q) begin
          largest_d = trunc_s[AW-1] ? VW'(-trunc_s) : VW'(trunc_s);
        end
        k_d  = k_q + 1'b1;
        st_d = (k_q == LAST_WHEEL) ? S_LCHK : S_PX;
      end
      S_LCHK: begin
        k_d  = '0;
        st_d = (largest_q > VW'(ONE)) ? S_SCL : S_OG;
      end
      S_SCL: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(v_mag) << FRACTION_BITS;
        div_dvs   = DVS_W'(largest_q);
        st_d      = S_SCLW;
      end
      S_SCLW: begin
        if (div_done) begin
          v_d[k_q] = v_q[k_q][VW-1] ? -VW'(div_quo) : VW'(div_quo);
          k_d      = k_q + 1'b1;
          st_d     = (k_q == LAST_WHEEL) ? S_OG : S_SCL;
        end
      end
      S_OG: begin
        if (!cfg_i.wheel_flags[k_q]) begin
          out_d[k_q] = '0;
          k_d        = k_q + 1'b1;
          st_d       = (k_q == LAST_WHEEL) ? S_EMIT : S_OG;
        end else begin
          t_d  = cfg_i.wheel_flags[4 + k_q] ? -trunc_p[17:0] : trunc_p[17:0];
          st_d = S_OL;
        end
      end
      S_OL: begin
        q_w = trunc_p[17:0];
        if (q_w > $signed({3'b000, lim})) begin
          q_w = $signed({3'b000, lim});
        end
        if (q_w < -$signed({3'b000, lim})) begin
          q_w = -$signed({3'b000, lim});
        end
        q_mag = q_w[17] ? 18'(-q_w) : 18'(q_w);
        neg_d = q_w[17];
        mag_d = q_mag[LEVEL_W-1:0];
        if (q_mag >= 18'(NEGLIGIBLE) && cfg_i.minimum_output != '0 && lim != '0) begin
          st_d = S_RM;
        end else begin
          out_d[k_q] = q_w[15:0];
          k_d        = k_q + 1'b1;
          st_d       = (k_q == LAST_WHEEL) ? S_EMIT : S_OG;
        end
      end
      S_RM: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_x[31:0]);
        div_dvs   = DVS_W'(lim);
        st_d      = S_RMW;
      end
      S_RMW: begin
        if (div_done) begin
          // lift the magnitude above the startup minimum, keep the sign
          rem_w      = 16'(e_min) + 16'(div_quo[LEVEL_W-1:0]);
          out_d[k_q] = neg_q ? -rem_w : rem_w;
          k_d        = k_q + 1'b1;
          st_d       = (k_q == LAST_WHEEL) ? S_EMIT : S_OG;
        end
      end
      S_EMIT: begin
        done_d = 1'b1;
        st_d   = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      k_q    <= '0;
      iter_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      k_q    <= k_d;
      iter_q <= iter_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    r_q       <= r_d;
    acc_q     <= acc_d;
    rad_q     <= rad_d;
    root_q    <= root_d;
    p_q       <= p_d;
    v_q       <= v_d;
    largest_q <= largest_d;
    t_q       <= t_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    out_q     <= out_d;
  end

  owdm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o               = done_q;
  assign result_o.wheel_zero  = out_q[0];
  assign result_o.wheel_one   = out_q[1];
  assign result_o.wheel_two   = out_q[2];
  assign result_o.wheel_three = out_q[3];

`ifndef SYNTH
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held longer than one cycle");
  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT) |=> done_q) else $error("finished command gave no strobe");
  a_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && !valid_i) |=> (st_q == S_IDLE && !done_q))
    else $error("sequencer left idle without a queued word");
  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (st_q == S_IDLE && valid_i)) else $error("queue popped while busy");
`endif

endmodule
